FILE: design/mlbf_pkg.sv
package mlbf_pkg;

  localparam int unsigned MacWidth = 48;

  typedef enum logic [1:0] {
    ACT_FORWARD = 2'd0,
    ACT_DROP    = 2'd1,
    ACT_FLOOD   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic [MacWidth-1:0] dest_mac;
    logic [MacWidth-1:0] src_mac;
    logic                in_port;
  } in_t;

  typedef struct packed {
    action_e action;
    logic    out_port;
    logic    learned_new;
    logic    table_full;
  } out_t;

  typedef struct packed {
    logic [MacWidth-1:0] mac;
    logic                port;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rd_more;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/mlbf_ram.sv
module mlbf_ram import mlbf_pkg::*; #(
  parameter int unsigned WIDTH = 49,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/mlbf_datapath.sv
module mlbf_datapath import mlbf_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_t        in_data_i,
  input  logic       out_stall_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  output out_t       out_data_o
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  in_t           item_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rd_ptr_q, rd_ptr_d;
  logic          cmp_vld_q;
  logic [IW-1:0] cmp_idx_q;
  logic          src_hit_q, src_hit_d;
  logic [IW-1:0] src_idx_q, src_idx_d;
  logic          dst_hit_q, dst_hit_d;
  logic          dst_port_q, dst_port_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, res_d;

  entry_t        rd_entry;
  entry_t        wr_entry;
  logic          ram_we;
  logic [IW-1:0] ram_addr;
  logic          room;
  logic          learned;
  logic          same_mac;

  assign room     = cnt_q < CW'(TABLE_ENTRIES);
  assign learned  = src_hit_q || room;
  assign same_mac = item_q.dest_mac == item_q.src_mac;

  assign ram_we        = cmd_i.commit && learned;
  assign ram_addr      = ram_we ? (src_hit_q ? src_idx_q : cnt_q[IW-1:0]) : rd_ptr_q[IW-1:0];
  assign wr_entry.mac  = item_q.src_mac;
  assign wr_entry.port = item_q.in_port;

  mlbf_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (wr_entry),
    .rdata_o (rd_entry)
  );

  always_comb begin
    src_hit_d  = src_hit_q;
    src_idx_d  = src_idx_q;
    dst_hit_d  = dst_hit_q;
    dst_port_d = dst_port_q;
    if (cmd_i.load) begin
      src_hit_d = 1'b0;
      dst_hit_d = 1'b0;
    end else if (cmp_vld_q) begin
      if (rd_entry.mac == item_q.src_mac) begin
        src_hit_d = 1'b1;
        src_idx_d = cmp_idx_q;
      end
      if (rd_entry.mac == item_q.dest_mac) begin
        dst_hit_d  = 1'b1;
        dst_port_d = rd_entry.port;
      end
    end
  end

  always_comb begin
    res_d.learned_new = !src_hit_q && room;
    res_d.table_full  = !src_hit_q && !room;
    if (same_mac && learned) begin
      res_d.action   = ACT_DROP;
      res_d.out_port = 1'b0;
    end else if (dst_hit_q && dst_port_q == item_q.in_port) begin
      res_d.action   = ACT_DROP;
      res_d.out_port = 1'b0;
    end else if (dst_hit_q) begin
      res_d.action   = ACT_FORWARD;
      res_d.out_port = dst_port_q;
    end else begin
      res_d.action   = ACT_FLOOD;
      res_d.out_port = !item_q.in_port;
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    rd_ptr_d    = rd_ptr_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.load) begin
      rd_ptr_d = '0;
    end else if (cmd_i.rd_en) begin
      rd_ptr_d = rd_ptr_q + CW'(1);
    end
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
      if (!src_hit_q && room) begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_ptr_q    <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rd_ptr_q    <= rd_ptr_d;
      cmp_vld_q   <= cmd_i.rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.rd_en) begin
      cmp_idx_q <= rd_ptr_q[IW-1:0];
    end
    if (cmd_i.commit) begin
      out_q <= res_d;
    end
    src_hit_q  <= src_hit_d;
    src_idx_q  <= src_idx_d;
    dst_hit_q  <= dst_hit_d;
    dst_port_q <= dst_port_d;
  end

  assign status_o.rd_more   = rd_ptr_q != cnt_q;
  assign status_o.scan_done = (rd_ptr_q == cnt_q) && !cmp_vld_q;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/mlbf_ctrl.sv
module mlbf_ctrl import mlbf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_stall_o   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.rd_more) begin
          cmd_o.rd_en = 1'b1;
        end else if (status_i.scan_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/mac_learning_bridge_forwarder_unit.sv
// Channel   Direction  Payload     Handshake
// in        input      in_t        in_valid_i / in_stall_o
// out       output     out_t       out_valid_o / out_stall_i
//
// Each frame header is scanned against the N stored entries (at most TABLE_ENTRIES),
// with one read per cycle of the table memory.
// Source and destination are compared against each entry in the same pass.
// Reset clears the entry count and the control state; the table needs no clearing.
// A new header is taken while a finished result still waits in the output register.
// A result that finds the output register full holds the table update until it drains.
module mac_learning_bridge_forwarder_unit import mlbf_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 512
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mlbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mlbf_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_o || !out_stall_i))
    else $error("Result written while the output register is still occupied.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("Input taken again right after a transfer.");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.learned_new && out_data_o.table_full))
    else $error("Source reported both learned and rejected.");

  a_drop_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.action == ACT_DROP) |-> !out_data_o.out_port)
    else $error("Dropped frame carries a nonzero port.");

  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.rd_en, cmd.commit}))
    else $error("Controller issued more than one command.");

endmodule
